FILE: hw/rtl/mcf_pkg.sv
// Shared types, codes and frame helpers for the motor command framer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mcf_pkg;

  // Operation codes of the input item
  localparam logic [2:0] OP_DRIVE = 3'd0;
  localparam logic [2:0] OP_QUERY = 3'd1;
  localparam logic [2:0] OP_MODE  = 3'd2;
  localparam logic [2:0] OP_SETID = 3'd3;
  localparam logic [2:0] OP_CHECK = 3'd4;
  localparam logic [2:0] OP_RX    = 3'd5;

  // Result kinds
  localparam logic KIND_TX    = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  // Fixed frame bytes
  localparam logic [7:0] CMD_DRIVE = 8'h64;
  localparam logic [7:0] CMD_QUERY = 8'h74;
  localparam logic [7:0] CMD_MODE  = 8'hA0;
  localparam logic [7:0] SETID_B0  = 8'hAA;
  localparam logic [7:0] SETID_B1  = 8'h55;
  localparam logic [7:0] SETID_B2  = 8'h53;
  localparam logic [7:0] CHECK_B0  = 8'hC8;
  localparam logic [7:0] CHECK_B1  = 8'h64;
  localparam logic [7:0] CRC_POLY  = 8'h8C;

  localparam int         FRAME_LEN   = 10;
  localparam int         IDX_W       = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] FRAME_LAST = IDX_W'(FRAME_LEN - 1);
  localparam int         REPLY_STORE = 9;
  localparam int         RCNT_W      = $clog2(REPLY_STORE + 1);
  localparam logic [RCNT_W-1:0] RCNT_FULL = RCNT_W'(REPLY_STORE);

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  motor_id;
    logic [15:0] speed;
    logic [7:0]  accel;
    logic [7:0]  brake;
    logic [7:0]  mode_value;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [7:0]  reply_id;
    logic [7:0]  reply_mode;
    logic [15:0] reply_current;
    logic [15:0] reply_speed;
    logic [15:0] reply_position;
    logic [7:0]  reply_temperature;
    logic [7:0]  reply_error;
  } res_t;

  // Command held for the serialiser
  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  motor_id;
    logic [15:0] speed;
    logic [7:0]  accel;
    logic [7:0]  brake;
    logic [7:0]  mode_value;
  } cmd_t;

  // One queue entry: either a frame to serialise or a finished reply
  typedef struct packed {
    logic is_reply;
    cmd_t cmd;
    res_t reply;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // One byte of CRC-8/MAXIM, reflected, already xored with the data byte
  function automatic logic [7:0] mcf_crc8_byte(logic [7:0] c_in);
    logic [7:0] c;
    c = c_in;
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic mcf_uses_crc(logic [2:0] op);
    logic r;
    case (op) inside
      OP_DRIVE, OP_QUERY, OP_CHECK: r = 1'b1;
      default:                      r = 1'b0;
    endcase
    return r;
  endfunction

  // Plain frame byte at an index; the CRC slot is filled by the caller
  function automatic logic [7:0] mcf_frame_byte(cmd_t c, logic [IDX_W-1:0] i);
    logic [7:0] b;
    b = 8'h00;
    unique case (c.op)
      OP_DRIVE: begin
        case (i)
          4'd0:    b = c.motor_id;
          4'd1:    b = CMD_DRIVE;
          4'd2:    b = c.speed[15:8];
          4'd3:    b = c.speed[7:0];
          4'd6:    b = c.accel;
          4'd7:    b = c.brake;
          default: b = 8'h00;
        endcase
      end
      OP_QUERY: begin
        case (i)
          4'd0:    b = c.motor_id;
          4'd1:    b = CMD_QUERY;
          default: b = 8'h00;
        endcase
      end
      OP_MODE: begin
        case (i)
          4'd0:       b = c.motor_id;
          4'd1:       b = CMD_MODE;
          FRAME_LAST: b = c.mode_value;
          default:    b = 8'h00;
        endcase
      end
      OP_SETID: begin
        case (i)
          4'd0:    b = SETID_B0;
          4'd1:    b = SETID_B1;
          4'd2:    b = SETID_B2;
          4'd3:    b = c.motor_id;
          default: b = 8'h00;
        endcase
      end
      default: begin
        case (i)
          4'd0:    b = CHECK_B0;
          4'd1:    b = CHECK_B1;
          default: b = 8'h00;
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mcf_front.sv
// Front end: accepts items, collects reply bytes and queues work for the back end.
// Depends on mcf_pkg.
`default_nettype none

module mcf_front
  import mcf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire item_t   item,
  input  wire q_stat_t q_stat,
  output logic         q_push,
  output entry_t       q_entry
);

  logic [7:0]        rbuf [REPLY_STORE];
  logic [RCNT_W-1:0] reply_count;
  logic              query_pending;
  logic              accept;

  assign accept = push && !q_stat.full;

  always_comb begin
    q_push                          = 1'b0;
    q_entry                         = '0;
    q_entry.cmd.op                  = item.op;
    q_entry.cmd.motor_id            = item.motor_id;
    q_entry.cmd.speed               = item.speed;
    q_entry.cmd.accel               = item.accel;
    q_entry.cmd.brake               = item.brake;
    q_entry.cmd.mode_value          = item.mode_value;
    q_entry.reply.kind              = KIND_REPLY;
    q_entry.reply.reply_id          = rbuf[0];
    q_entry.reply.reply_mode        = rbuf[1];
    q_entry.reply.reply_current     = {rbuf[2], rbuf[3]};
    q_entry.reply.reply_speed       = {rbuf[4], rbuf[5]};
    q_entry.reply.reply_error       = rbuf[8];
    if (query_pending) begin
      q_entry.reply.reply_position    = {8'h00, rbuf[7]};
      q_entry.reply.reply_temperature = rbuf[6];
    end else begin
      q_entry.reply.reply_position    = {rbuf[6], rbuf[7]};
      q_entry.reply.reply_temperature = 8'h00;
    end
    if (item.op == OP_RX) begin
      q_entry.is_reply = 1'b1;
      q_push           = accept && (reply_count == RCNT_FULL);
    end else if (item.op <= OP_CHECK) begin
      q_push           = accept;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_count   <= '0;
      query_pending <= 1'b0;
    end else if (accept) begin
      if (item.op == OP_RX) begin
        if (reply_count == RCNT_FULL) begin
          reply_count <= '0;
        end else begin
          reply_count <= reply_count + 1'b1;
        end
      end else if (item.op <= OP_CHECK) begin
        reply_count   <= '0;
        query_pending <= (item.op == OP_QUERY);
      end
    end
  end

  // Store a reply byte; the tenth (CRC) byte is dropped
  always_ff @(posedge clk) begin
    if (accept && item.op == OP_RX && reply_count != RCNT_FULL) begin
      rbuf[reply_count] <= item.rx_byte;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mcf_queue.sv
// Short queue between the front and back ends of the motor command framer.
// Depends on mcf_pkg.
`default_nettype none

module mcf_queue
  import mcf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_data,
  input  wire logic   pop,
  output entry_t      pop_data,
  output q_stat_t     stat
);

  entry_t             mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign stat.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mcf_back.sv
// Back end: serialises frames byte by byte with a running CRC and holds the result register.
// Depends on mcf_pkg.
`default_nettype none

module mcf_back
  import mcf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire q_stat_t q_stat,
  input  wire entry_t  q_data,
  output logic         q_pop,
  input  wire logic    pop,
  output logic         empty,
  output res_t         result
);

  entry_t           cur;
  logic             cur_valid;
  logic [IDX_W-1:0] idx;
  logic [7:0]       crc;
  logic             out_valid;
  res_t             out_data;

  logic             advance;
  logic             finish;
  logic [7:0]       raw_byte;
  logic [7:0]       tx_byte;
  logic [7:0]       crc_next;
  res_t             res_next;

  assign advance  = cur_valid && (!out_valid || pop);
  assign finish   = advance && (cur.is_reply || idx == FRAME_LAST);
  assign q_pop    = !q_stat.empty && (!cur_valid || finish);
  assign raw_byte = mcf_frame_byte(cur.cmd, idx);
  assign tx_byte  = (idx == FRAME_LAST && mcf_uses_crc(cur.cmd.op)) ? crc : raw_byte;
  assign crc_next = mcf_crc8_byte(crc ^ raw_byte);

  always_comb begin
    if (cur.is_reply) begin
      res_next = cur.reply;
    end else begin
      res_next         = '0;
      res_next.kind    = KIND_TX;
      res_next.tx_byte = tx_byte;
      res_next.last    = (idx == FRAME_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
      crc       <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx       <= idx + 1'b1;
        crc       <= crc_next;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      // Load the next entry when idle or as the current one finishes
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
        crc       <= '0;
      end else if (finish) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (advance) begin
      out_data <= res_next;
    end
  end

  assign empty  = !out_valid;
  assign result = out_data;

endmodule

`default_nettype wire

FILE: hw/rtl/motor_command_framer_unit.sv
// Motor command framer: a command request yields ten frame bytes, one per cycle
// while the output is free or popped; the tenth received byte of a reply yields
// one parsed reply. A first result passes through the queue, the current-entry
// register and the output register; the serialiser stalls while a result waits.
// Synchronous active-high reset empties the queue and output and clears the
// reply count and the query flag; the reply byte store is not cleared.
`default_nettype none

module motor_command_framer_unit
  import mcf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  output logic       full,
  input  wire item_t item,
  output logic       empty,
  input  wire logic  pop,
  output res_t       result
);

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  entry_t  q_entry;
  entry_t  q_data;

  // Hold off requests only while the queue has no room
  assign full = q_stat.full;

  // Front: classify requests, gather reply bytes, queue frames and replies
  mcf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item    (item),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  // Queue: decouple acceptance from serialisation
  mcf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_entry),
    .pop       (q_pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  // Back: advance one byte per cycle into the output register while it is free or popped
  mcf_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .q_data (q_data),
    .q_pop  (q_pop),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/mcf_checker.sv
// Port-level checks for the motor command framer, bound to the top level.
// Depends on mcf_pkg.
`default_nettype none

module mcf_checker
  import mcf_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  input wire logic  full,
  input wire logic  empty,
  input wire logic  pop,
  input wire res_t  result
);

  // A waiting result holds until it is taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result changed while stalled");

  // Reset leaves both sides empty
  a_reset: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("not empty after reset");

  // Frame bytes run on without a reply between them
  a_frame_run: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && result.kind == KIND_TX && !result.last)
      |=> (empty || result.kind == KIND_TX))
    else $error("frame interrupted by a reply");

  // A parsed reply carries no transmit byte
  a_reply_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kind == KIND_REPLY) |-> (!result.last && result.tx_byte == 8'h00))
    else $error("reply carries transmit fields");

endmodule

bind motor_command_framer_unit mcf_checker u_chk (.*);

`default_nettype wire
